// File: sv/pid_hb_pkg.sv
// ----------------------------------------------------------------------------
// pid_hb_pkg
// Shared constants for the PID H-bridge drive: gain register map, gain reset
// values and the internal widths of the product and sum path.
// ----------------------------------------------------------------------------
`default_nettype none

package pid_hb_pkg;

   // Gain registers are unsigned fixed point, fixed width.
   localparam int GAIN_BITS = 24;

   // Register index map on the configuration port.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KP = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KI = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_KD = 2'd2;

   // Reset values: kp = 1.1, ki = 0.00225 * 0.1, kd = 0.15 / 0.1.
   localparam logic [GAIN_BITS-1:0] KP_RESET = 24'd72090;
   localparam logic [GAIN_BITS-1:0] KI_RESET = 24'd15;
   localparam logic [GAIN_BITS-1:0] KD_RESET = 24'd98304;

   // The integral is sign extended to WIDE_INT_BITS and split in two halves
   // of SPLIT_BITS so that each multiplier stays near 24 x 24.
   localparam int WIDE_INT_BITS = 48;
   localparam int SPLIT_BITS    = 24;

   // Width of the summed control term; holds every reachable total exactly.
   localparam int TOT_BITS = 76;

endpackage

`default_nettype wire

// File: sv/pid_hb_csr.sv
// ----------------------------------------------------------------------------
// pid_hb_csr
// Gain register file: three writable gains behind a valid/ready write port.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_hb_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [pid_hb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [pid_hb_pkg::GAIN_BITS-1:0]      csr_data,
   output logic      [pid_hb_pkg::GAIN_BITS-1:0]      kp_gain,
   output logic      [pid_hb_pkg::GAIN_BITS-1:0]      ki_gain,
   output logic      [pid_hb_pkg::GAIN_BITS-1:0]      kd_gain
);

   logic [pid_hb_pkg::GAIN_BITS-1:0] kp_ff, kp_in;
   logic [pid_hb_pkg::GAIN_BITS-1:0] ki_ff, ki_in;
   logic [pid_hb_pkg::GAIN_BITS-1:0] kd_ff, kd_in;

   assign csr_ready = 1'b1;

   always_comb begin
      kp_in = kp_ff;
      ki_in = ki_ff;
      kd_in = kd_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pid_hb_pkg::REG_KP: kp_in = csr_data;
            pid_hb_pkg::REG_KI: ki_in = csr_data;
            pid_hb_pkg::REG_KD: kd_in = csr_data;
            default: ;  // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= pid_hb_pkg::KP_RESET;
         ki_ff <= pid_hb_pkg::KI_RESET;
         kd_ff <= pid_hb_pkg::KD_RESET;
      end else begin
         kp_ff <= kp_in;
         ki_ff <= ki_in;
         kd_ff <= kd_in;
      end
   end

   assign kp_gain = kp_ff;
   assign ki_gain = ki_ff;
   assign kd_gain = kd_ff;

endmodule

`default_nettype wire

// File: sv/pid_hb_err.sv
// ----------------------------------------------------------------------------
// pid_hb_err
// Input stage: forms the error, updates the saturating integral and the
// previous error, and registers error, integral and derivative.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_hb_err #(
   parameter int SAMPLE_BITS   = 10,
   parameter int INTEGRAL_BITS = 24
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic        [SAMPLE_BITS-1:0]   req_target_sample,
   input  wire logic        [SAMPLE_BITS-1:0]   req_measured_sample,
   output logic                                 out_valid,
   input  wire logic                            out_stall,
   output logic signed      [SAMPLE_BITS:0]     err_out,
   output logic signed      [INTEGRAL_BITS-1:0] isum_out,
   output logic signed      [SAMPLE_BITS+1:0]   deriv_out
);

   localparam int ERR_BITS = SAMPLE_BITS + 1;
   localparam int DER_BITS = SAMPLE_BITS + 2;
   localparam int ACC_BITS =
      ((INTEGRAL_BITS > ERR_BITS) ? INTEGRAL_BITS : ERR_BITS) + 1;
   localparam logic signed [ACC_BITS-1:0] IMAX =
      ACC_BITS'((longint'(1) <<< (INTEGRAL_BITS - 1)) - longint'(1));
   localparam logic signed [ACC_BITS-1:0] IMIN = -IMAX - ACC_BITS'(1);

   logic                             valid_ff, valid_in;
   logic signed [INTEGRAL_BITS-1:0]  error_sum_ff, error_sum_in;
   logic signed [ERR_BITS-1:0]       prev_err_ff, prev_err_in;
   logic signed [ERR_BITS-1:0]       err_ff;
   logic signed [INTEGRAL_BITS-1:0]  isum_ff;
   logic signed [DER_BITS-1:0]       deriv_ff;
   logic signed [ERR_BITS-1:0]       err_now;
   logic signed [ACC_BITS-1:0]       acc;
   logic signed [DER_BITS-1:0]       deriv_now;
   logic                             load;
   logic                             accept;

   assign req_stall = valid_ff && out_stall;
   assign load      = !req_stall;
   assign accept    = req_valid && load;

   assign err_now   = $signed({1'b0, req_target_sample}) -
                      $signed({1'b0, req_measured_sample});
   assign acc       = ACC_BITS'(error_sum_ff) + ACC_BITS'(err_now);
   assign deriv_now = DER_BITS'(err_now) - DER_BITS'(prev_err_ff);

   always_comb begin
      valid_in     = load ? req_valid : valid_ff;
      error_sum_in = error_sum_ff;
      prev_err_in  = prev_err_ff;
      if (accept) begin
         prev_err_in = err_now;
         if (acc > IMAX) begin
            error_sum_in = INTEGRAL_BITS'(IMAX);
         end else if (acc < IMIN) begin
            error_sum_in = INTEGRAL_BITS'(IMIN);
         end else begin
            error_sum_in = INTEGRAL_BITS'(acc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else begin
         valid_ff     <= valid_in;
         error_sum_ff <= error_sum_in;
         prev_err_ff  <= prev_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff   <= err_now;
         isum_ff  <= error_sum_in;
         deriv_ff <= deriv_now;
      end
   end

   assign out_valid = valid_ff;
   assign err_out   = err_ff;
   assign isum_out  = isum_ff;
   assign deriv_out = deriv_ff;

   a_prev_tracks_err: assert property (@(posedge clock) disable iff (reset)
      accept |=> prev_err_ff == err_ff)
      else $error("previous error does not follow the accepted item");

   a_isum_tracks_state: assert property (@(posedge clock) disable iff (reset)
      accept |=> isum_ff == error_sum_ff)
      else $error("registered integral differs from integral state");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> valid_ff)
      else $error("input stalled with an empty stage");

endmodule

`default_nettype wire

// File: sv/pid_hb_mult.sv
// ----------------------------------------------------------------------------
// pid_hb_mult
// Product stage: multiplies error, integral and derivative by their gains.
// The integral product is split into two half-width products.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_hb_mult #(
   parameter int SAMPLE_BITS   = 10,
   parameter int INTEGRAL_BITS = 24
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     in_valid,
   output logic                                          in_stall,
   input  wire logic signed [SAMPLE_BITS:0]              err_in,
   input  wire logic signed [INTEGRAL_BITS-1:0]          isum_in,
   input  wire logic signed [SAMPLE_BITS+1:0]            deriv_in,
   input  wire logic        [pid_hb_pkg::GAIN_BITS-1:0]  kp_gain,
   input  wire logic        [pid_hb_pkg::GAIN_BITS-1:0]  ki_gain,
   input  wire logic        [pid_hb_pkg::GAIN_BITS-1:0]  kd_gain,
   output logic                                          out_valid,
   input  wire logic                                     out_stall,
   output logic signed      [SAMPLE_BITS:0]              err_out,
   output logic signed      [pid_hb_pkg::GAIN_BITS+SAMPLE_BITS+1:0] prop_out,
   output logic signed      [pid_hb_pkg::GAIN_BITS+SAMPLE_BITS+2:0] der_out,
   output logic             [2*pid_hb_pkg::SPLIT_BITS-1:0]          int_lo_out,
   output logic signed      [2*pid_hb_pkg::SPLIT_BITS:0]            int_hi_out
);

   localparam int GB      = pid_hb_pkg::GAIN_BITS;
   localparam int SPB     = pid_hb_pkg::SPLIT_BITS;
   localparam int WIB     = pid_hb_pkg::WIDE_INT_BITS;
   localparam int P_BITS  = GB + SAMPLE_BITS + 2;
   localparam int D_BITS  = GB + SAMPLE_BITS + 3;

   logic                        valid_ff, valid_in;
   logic signed [SAMPLE_BITS:0] err_ff;
   logic signed [P_BITS-1:0]    prop_ff;
   logic signed [D_BITS-1:0]    der_ff;
   logic        [2*SPB-1:0]     int_lo_ff;
   logic signed [2*SPB:0]       int_hi_ff;
   logic signed [WIB-1:0]       isum_wide;
   logic        [SPB-1:0]       isum_lo;
   logic signed [SPB-1:0]       isum_hi;
   logic                        load;

   assign in_stall  = valid_ff && out_stall;
   assign load      = !in_stall;
   assign valid_in  = load ? in_valid : valid_ff;

   assign isum_wide = WIB'(isum_in);
   assign isum_lo   = isum_wide[SPB-1:0];
   assign isum_hi   = isum_wide[WIB-1:SPB];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff    <= err_in;
         prop_ff   <= $signed({1'b0, kp_gain}) * err_in;
         der_ff    <= $signed({1'b0, kd_gain}) * deriv_in;
         int_lo_ff <= ki_gain * isum_lo;
         int_hi_ff <= $signed({1'b0, ki_gain}) * isum_hi;
      end
   end

   assign out_valid  = valid_ff;
   assign err_out    = err_ff;
   assign prop_out   = prop_ff;
   assign der_out    = der_ff;
   assign int_lo_out = int_lo_ff;
   assign int_hi_out = int_hi_ff;

endmodule

`default_nettype wire

// File: sv/pid_hb_out.sv
// ----------------------------------------------------------------------------
// pid_hb_out
// Sum and drive stages: adds the gain products, then truncates toward zero,
// clamps to the duty limit and splits the result into bridge duties.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_hb_out #(
   parameter int SAMPLE_BITS    = 10,
   parameter int DUTY_MAX       = 255,
   parameter int GAIN_FRAC_BITS = 16,
   parameter int DUTY_BITS      = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   output logic                                       in_stall,
   input  wire logic signed [SAMPLE_BITS:0]           err_in,
   input  wire logic signed [pid_hb_pkg::GAIN_BITS+SAMPLE_BITS+1:0] prop_in,
   input  wire logic signed [pid_hb_pkg::GAIN_BITS+SAMPLE_BITS+2:0] der_in,
   input  wire logic        [2*pid_hb_pkg::SPLIT_BITS-1:0]          int_lo_in,
   input  wire logic signed [2*pid_hb_pkg::SPLIT_BITS:0]            int_hi_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic             [DUTY_BITS-1:0]           rsp_drive_left,
   output logic             [DUTY_BITS-1:0]           rsp_drive_right,
   output logic signed      [DUTY_BITS:0]             rsp_control_value,
   output logic signed      [SAMPLE_BITS:0]           rsp_error_value
);

   localparam int TB  = pid_hb_pkg::TOT_BITS;
   localparam int SPB = pid_hb_pkg::SPLIT_BITS;
   localparam int CB  = DUTY_BITS + 1;

   logic                        sum_valid_ff, sum_valid_in;
   logic signed [TB-1:0]        total_ff;
   logic signed [SAMPLE_BITS:0] sum_err_ff;
   logic                        sum_stall;
   logic                        sum_load;

   logic                        out_valid_ff, out_valid_in;
   logic        [DUTY_BITS-1:0] left_ff;
   logic        [DUTY_BITS-1:0] right_ff;
   logic signed [CB-1:0]        ctl_ff;
   logic signed [SAMPLE_BITS:0] out_err_ff;
   logic                        out_load;

   logic                        neg;
   logic        [TB-1:0]        mag;
   logic        [TB-1:0]        mag_int;
   logic        [DUTY_BITS-1:0] duty;
   logic signed [CB-1:0]        ctl_now;

   // Sum stage.
   assign out_load     = !(out_valid_ff && rsp_stall);
   assign sum_stall    = sum_valid_ff && !out_load;
   assign sum_load     = !sum_stall;
   assign in_stall     = sum_stall;
   assign sum_valid_in = sum_load ? in_valid : sum_valid_ff;

   always_ff @(posedge clock) begin
      if (sum_load) begin
         total_ff   <= TB'(prop_in) + TB'(der_in) + TB'(int_lo_in) +
                       (TB'(int_hi_in) <<< SPB);
         sum_err_ff <= err_in;
      end
   end

   // Drive stage: truncate the magnitude, then restore the sign.
   assign neg     = total_ff[TB-1];
   assign mag     = neg ? (TB'(0) - total_ff) : total_ff;
   assign mag_int = mag >> GAIN_FRAC_BITS;
   assign duty    = (mag_int > TB'(DUTY_MAX)) ? DUTY_BITS'(DUTY_MAX)
                                              : mag_int[DUTY_BITS-1:0];
   assign ctl_now = neg ? (CB'(0) - CB'(duty)) : CB'(duty);

   assign out_valid_in = out_load ? sum_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (out_load) begin
         left_ff    <= neg ? '0 : duty;
         right_ff   <= neg ? duty : '0;
         ctl_ff     <= ctl_now;
         out_err_ff <= sum_err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_drive_left    = left_ff;
   assign rsp_drive_right   = right_ff;
   assign rsp_control_value = ctl_ff;
   assign rsp_error_value   = out_err_ff;

   a_one_side_driven: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_left == '0 || rsp_drive_right == '0))
      else $error("both bridge sides driven at once");

   a_left_matches_ctl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_control_value[CB-1] |->
         rsp_drive_left == rsp_control_value[DUTY_BITS-1:0])
      else $error("left duty differs from positive control");

   a_sum_moves_on: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && !sum_stall |=> out_valid_ff)
      else $error("summed item lost before the drive stage");

endmodule

`default_nettype wire

// File: sv/pid_hbridge_drive_core.sv
// ----------------------------------------------------------------------------
// pid_hbridge_drive_core
// Discrete PID controller driving an H-bridge.
//
// req_ channel: one item per control tick with a setpoint and a feedback
// sample. rsp_ channel: one result per item with left and right bridge
// duties, the clamped signed control value and the error. Both channels
// use valid/stall; an item moves when valid is high and stall is low.
// csr_ channel: valid/ready write of the gains (index 0 kp, 1 ki, 2 kd);
// ready is always high. Write gains only while no item is in flight.
// Pipeline: four register stages (error/integral, gain products, sum, drive).
// Throughput: one item per cycle while no stall holds the stages; the
// integral update closes in the first stage, so back-to-back items see
// each other's state.
// Reset clears the integral, the previous error and all stage valids, and
// loads the default gains. While rsp_stall is high the result holds; the
// stages behind it keep filling and req_stall rises once they are full.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_hbridge_drive_core #(
   parameter int SAMPLE_BITS    = 10,
   parameter int DUTY_MAX       = 255,
   parameter int INTEGRAL_BITS  = 24,
   parameter int GAIN_FRAC_BITS = 16,
   localparam int DUTY_BITS     = $clog2(DUTY_MAX + 1)
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic        [SAMPLE_BITS-1:0]         req_target_sample,
   input  wire logic        [SAMPLE_BITS-1:0]         req_measured_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic             [DUTY_BITS-1:0]           rsp_drive_left,
   output logic             [DUTY_BITS-1:0]           rsp_drive_right,
   output logic signed      [DUTY_BITS:0]             rsp_control_value,
   output logic signed      [SAMPLE_BITS:0]           rsp_error_value,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [pid_hb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [pid_hb_pkg::GAIN_BITS-1:0]      csr_data
);

   localparam int GB  = pid_hb_pkg::GAIN_BITS;
   localparam int SPB = pid_hb_pkg::SPLIT_BITS;

   logic [GB-1:0]                 kp_gain;
   logic [GB-1:0]                 ki_gain;
   logic [GB-1:0]                 kd_gain;

   logic                          e_valid;
   logic                          e_stall;
   logic signed [SAMPLE_BITS:0]   e_err;
   logic signed [INTEGRAL_BITS-1:0] e_isum;
   logic signed [SAMPLE_BITS+1:0] e_deriv;

   logic                          m_valid;
   logic                          m_stall;
   logic signed [SAMPLE_BITS:0]   m_err;
   logic signed [GB+SAMPLE_BITS+1:0] m_prop;
   logic signed [GB+SAMPLE_BITS+2:0] m_der;
   logic        [2*SPB-1:0]       m_int_lo;
   logic signed [2*SPB:0]         m_int_hi;

   pid_hb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .kp_gain   (kp_gain),
      .ki_gain   (ki_gain),
      .kd_gain   (kd_gain)
   );

   pid_hb_err #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .INTEGRAL_BITS (INTEGRAL_BITS)
   ) u_err (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_target_sample   (req_target_sample),
      .req_measured_sample (req_measured_sample),
      .out_valid           (e_valid),
      .out_stall           (e_stall),
      .err_out             (e_err),
      .isum_out            (e_isum),
      .deriv_out           (e_deriv)
   );

   pid_hb_mult #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .INTEGRAL_BITS (INTEGRAL_BITS)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (e_valid),
      .in_stall   (e_stall),
      .err_in     (e_err),
      .isum_in    (e_isum),
      .deriv_in   (e_deriv),
      .kp_gain    (kp_gain),
      .ki_gain    (ki_gain),
      .kd_gain    (kd_gain),
      .out_valid  (m_valid),
      .out_stall  (m_stall),
      .err_out    (m_err),
      .prop_out   (m_prop),
      .der_out    (m_der),
      .int_lo_out (m_int_lo),
      .int_hi_out (m_int_hi)
   );

   pid_hb_out #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .DUTY_MAX       (DUTY_MAX),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .DUTY_BITS      (DUTY_BITS)
   ) u_out (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (m_valid),
      .in_stall          (m_stall),
      .err_in            (m_err),
      .prop_in           (m_prop),
      .der_in            (m_der),
      .int_lo_in         (m_int_lo),
      .int_hi_in         (m_int_hi),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_left    (rsp_drive_left),
      .rsp_drive_right   (rsp_drive_right),
      .rsp_control_value (rsp_control_value),
      .rsp_error_value   (rsp_error_value)
   );

endmodule

`default_nettype wire

// File: tb/pid_hbridge_drive_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_hbridge_drive_core_test
// Self-checking bench for the PID H-bridge drive core. A table of directed
// ticks runs first, then random ticks under several gain settings. Every
// result is checked field by field against its table row or the in-bench PID
// predictor, with random request gaps and result stalls save in the last phase.
// ----------------------------------------------------------------------------

module pid_hbridge_drive_core_test;

   localparam int     GAIN_BITS      = pid_hb_pkg::GAIN_BITS;
   localparam int     CSR_INDEX_BITS = pid_hb_pkg::CSR_INDEX_BITS;
   localparam int     SAMPLE_BITS   = 10;
   localparam int     INTEGRAL_BITS = 24;
   localparam int     FRAC_BITS     = 16;
   localparam longint DUTY_LIMIT    = 255;
   localparam int     SAMPLE_MAX    = 1023;
   localparam longint INTEG_MAX     = (64'sd1 <<< (INTEGRAL_BITS - 1)) - 1;
   localparam longint INTEG_MIN     = -INTEG_MAX - 1;
   localparam logic [GAIN_BITS-1:0] GAIN_MAX = '1;
   // Index 3 is not mapped; the core drops writes to it.
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;
   localparam int     NUM_ROWS      = 14;

   typedef struct packed {
      logic        [7:0]  left;
      logic        [7:0]  right;
      logic signed [8:0]  control;
      logic signed [10:0] error;
   } drive_result_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] target;
      logic [SAMPLE_BITS-1:0] measured;
      logic                   typed;
      drive_result_type       result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [SAMPLE_BITS-1:0] req_target_sample;
   logic [SAMPLE_BITS-1:0] req_measured_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_drive_left;
   logic [7:0] rsp_drive_right;
   logic signed [8:0] rsp_control_value;
   logic signed [10:0] rsp_error_value;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [GAIN_BITS-1:0] csr_data;

   // Predictor state and gains.
   logic [GAIN_BITS-1:0] gain_p;
   logic [GAIN_BITS-1:0] gain_i;
   logic [GAIN_BITS-1:0] gain_d;
   longint integ_acc;
   longint last_err;

   drive_result_type expected_drives[$];
   stim_row_type     stim_rows[NUM_ROWS];
   int               fail_count = 0;
   bit               quiet = 1'b0;
   int               stall_run = 0;

   pid_hbridge_drive_core i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_target_sample   (req_target_sample),
      .req_measured_sample (req_measured_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive_left      (rsp_drive_left),
      .rsp_drive_right     (rsp_drive_right),
      .rsp_control_value   (rsp_control_value),
      .rsp_error_value     (rsp_error_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One control tick: saturating integral, three gain products, truncate
   // toward zero, clamp and split by sign. Products stay below 2^48 at these
   // widths, so the term cap never comes into play.
   function automatic drive_result_type predict_drive(input logic [SAMPLE_BITS-1:0] tgt,
                                                      input logic [SAMPLE_BITS-1:0] meas);
      longint           err;
      longint           total;
      longint           mag;
      bit               neg;
      drive_result_type res;
      err = longint'(tgt) - longint'(meas);
      integ_acc = integ_acc + err;
      if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
      if (integ_acc < INTEG_MIN) integ_acc = INTEG_MIN;
      total = longint'(gain_p) * err + longint'(gain_i) * integ_acc
            + longint'(gain_d) * (err - last_err);
      last_err = err;
      neg = total < 0;
      mag = neg ? -total : total;
      mag = mag >> FRAC_BITS;
      if (mag > DUTY_LIMIT) mag = DUTY_LIMIT;
      res.left    = (!neg && mag != 0) ? 8'(mag) : 8'd0;
      res.right   = (neg && mag != 0) ? 8'(mag) : 8'd0;
      res.control = neg ? 9'(-mag) : 9'(mag);
      res.error   = 11'(err);
      return res;
   endfunction

   task automatic send_sample(input logic [SAMPLE_BITS-1:0] tgt,
                              input logic [SAMPLE_BITS-1:0] meas,
                              input logic typed, input drive_result_type typed_res);
      int               gap;
      int               r;
      drive_result_type pred;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_target_sample   <= tgt;
      req_measured_sample <= meas;
      do @(posedge clock); while (req_stall);
      pred = predict_drive(tgt, meas);
      expected_drives.push_back(typed ? typed_res : pred);
   endtask

   // Drop valid, then wait for the pipeline to empty.
   task automatic drain_pipe();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_gain(input logic [CSR_INDEX_BITS-1:0] idx,
                             input logic [GAIN_BITS-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         pid_hb_pkg::REG_KP: gain_p = val;
         pid_hb_pkg::REG_KI: gain_i = val;
         pid_hb_pkg::REG_KD: gain_d = val;
         default: ;
      endcase
   endtask

   task automatic program_gains(input logic [GAIN_BITS-1:0] kp,
                                input logic [GAIN_BITS-1:0] ki,
                                input logic [GAIN_BITS-1:0] kd);
      write_gain(pid_hb_pkg::REG_KP, kp);
      write_gain(REG_UNMAPPED, GAIN_BITS'($urandom));
      write_gain(pid_hb_pkg::REG_KI, ki);
      write_gain(pid_hb_pkg::REG_KD, kd);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side backpressure: runs of ready and stall, a few of them long.
   always @(negedge clock) begin : stall_gen
      int r;
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_run = 0;
      end else if (stall_run > 0) begin
         stall_run--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_stall <= 1'b0;
            stall_run = $urandom_range(0, 8);
         end else if (r < 92) begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_run = $urandom_range(10, 50);
         end
      end
   end

   always @(posedge clock) begin : check_results
      drive_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_drives.size() == 0) begin
            $error("result with no item pending");
            fail_count++;
         end else begin
            want = expected_drives.pop_front();
            if (rsp_drive_left !== want.left) begin
               $error("drive_left: expected %0d, got %0d", want.left, rsp_drive_left);
               fail_count++;
            end
            if (rsp_drive_right !== want.right) begin
               $error("drive_right: expected %0d, got %0d", want.right, rsp_drive_right);
               fail_count++;
            end
            if (rsp_control_value !== want.control) begin
               $error("control_value: expected %0d, got %0d", want.control,
                      rsp_control_value);
               fail_count++;
            end
            if (rsp_error_value !== want.error) begin
               $error("error_value: expected %0d, got %0d", want.error, rsp_error_value);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int                     r;
      int                     tv;
      logic [SAMPLE_BITS-1:0] t;
      logic [SAMPLE_BITS-1:0] m;
      logic [GAIN_BITS-1:0]   kp;
      logic [GAIN_BITS-1:0]   ki;
      logic [GAIN_BITS-1:0]   kd;

      reset               = 1'b1;
      req_valid           = 1'b0;
      req_target_sample   = '0;
      req_measured_sample = '0;
      rsp_stall           = 1'b0;
      csr_valid           = 1'b0;
      csr_index           = '0;
      csr_data            = '0;
      gain_p              = pid_hb_pkg::KP_RESET;
      gain_i              = pid_hb_pkg::KI_RESET;
      gain_d              = pid_hb_pkg::KD_RESET;
      integ_acc           = 0;
      last_err            = 0;

      // Rows run from reset with the default gains; full-scale error clamps.
      stim_rows = '{
         '{10'd0,    10'd0,    1'b1, '{8'd0,   8'd0,   9'sd0,    11'sd0}},
         '{10'd1023, 10'd0,    1'b1, '{8'd255, 8'd0,   9'sd255,  11'sd1023}},
         '{10'd0,    10'd1023, 1'b1, '{8'd0,   8'd255, -9'sd255, -11'sd1023}},
         '{10'd512,  10'd512,  1'b0, '0},
         '{10'd1023, 10'd1023, 1'b1, '{8'd0,   8'd0,   9'sd0,    11'sd0}},
         '{10'd1,    10'd0,    1'b0, '0},
         '{10'd0,    10'd1,    1'b0, '0},
         '{10'd600,  10'd400,  1'b0, '0},
         '{10'd400,  10'd600,  1'b0, '0},
         '{10'd341,  10'd682,  1'b0, '0},
         '{10'd682,  10'd341,  1'b0, '0},
         '{10'd1023, 10'd1022, 1'b0, '0},
         '{10'd5,    10'd1020, 1'b0, '0},
         '{10'd700,  10'd700,  1'b0, '0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++)
         send_sample(stim_rows[i].target, stim_rows[i].measured,
                     stim_rows[i].typed, stim_rows[i].result);
      drain_pipe();

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin
               kp = pid_hb_pkg::KP_RESET;
               ki = pid_hb_pkg::KI_RESET;
               kd = pid_hb_pkg::KD_RESET;
            end
            1: begin kp = '0; ki = '0; kd = '0; end
            2: begin kp = GAIN_MAX; ki = GAIN_MAX; kd = GAIN_MAX; end
            3: begin kp = GAIN_MAX; ki = '0; kd = '0; end
            5: begin
               kp = GAIN_BITS'($urandom);
               ki = GAIN_BITS'($urandom);
               kd = GAIN_BITS'($urandom);
            end
            default: begin
               kp = GAIN_BITS'($urandom_range(0, 1 << 18));
               ki = GAIN_BITS'($urandom_range(0, 1 << 6));
               kd = GAIN_BITS'($urandom_range(0, 1 << 18));
            end
         endcase
         quiet = (ph == 6);
         program_gains(kp, ki, kd);
         for (int n = 0; n < 150; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
               t = SAMPLE_BITS'($urandom);
               m = SAMPLE_BITS'($urandom);
            end else if (r < 75) begin
               // Keep the error small so the output is less likely to hit the clamp.
               m  = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
               tv = int'(m) + int'($urandom_range(0, 40)) - 20;
               if (tv < 0) tv = 0;
               if (tv > SAMPLE_MAX) tv = SAMPLE_MAX;
               t = SAMPLE_BITS'(tv);
            end else begin
               t = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
               m = $urandom_range(0, 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
            end
            send_sample(t, m, 1'b0, '0);
         end
         drain_pipe();
      end

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
